[sv/assert_macros.svh]
// Assertion macros for the checker file of the interval table block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IUMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IUMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/iumt_pkg.sv]
// Package for the interval union membership table: operation and status codes,
// sequencer state type and the compare flags of the span unit. No dependencies.
`default_nettype none

package iumt_pkg;

  // Fixed field widths.
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int HIT_BITS    = 32;

  // Operation codes.
  localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ORDER = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_PLACE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_WRITE,
    S_QRY_RD,
    S_QRY_EV,
    S_DONE
  } state_t;

  // Compare results of a stored entry [start, end] against the two keys.
  typedef struct packed {
    logic end_below_lo;    // entry end < low key
    logic hi_below_start;  // high key < entry start
    logic start_below_lo;  // entry start < low key
    logic hi_below_end;    // high key < entry end
  } cmp_flags_t;

endpackage

`default_nettype wire

[sv/iumt_span_unit.sv]
// Shared compare and span arithmetic unit of the interval table sequencer.
// Depends on iumt_pkg for the compare flag structure.
`default_nettype none

module iumt_span_unit #(
  parameter int ID_BITS = 48
) (
  input  logic [ID_BITS-1:0]   entry_start,
  input  logic [ID_BITS-1:0]   entry_end,
  input  logic [ID_BITS-1:0]   key_lo,
  input  logic [ID_BITS-1:0]   key_hi,
  input  logic                 add_span,
  input  logic [ID_BITS-1:0]   span_lo,
  input  logic [ID_BITS-1:0]   span_hi,
  input  logic [ID_BITS:0]     acc,
  output iumt_pkg::cmp_flags_t flags,
  output logic [ID_BITS:0]     sum
);
  import iumt_pkg::*;

  localparam int SUM_BITS = ID_BITS + 1;

  logic [SUM_BITS-1:0] opnd_p;
  logic [SUM_BITS-1:0] opnd_q;
  logic [SUM_BITS-1:0] carry_in;

  // Entry against key compares, used by both the add scan and the query search.
  assign flags.end_below_lo   = (entry_end < key_lo);
  assign flags.hi_below_start = (key_hi < entry_start);
  assign flags.start_below_lo = (entry_start < key_lo);
  assign flags.hi_below_end   = (key_hi < entry_end);

  // Adding a span gives acc + hi - lo + 1; removing one gives acc + lo - hi - 1.
  // Both are acc + p + ~q plus a small constant.
  assign opnd_p   = add_span ? SUM_BITS'(span_hi) : SUM_BITS'(span_lo);
  assign opnd_q   = add_span ? SUM_BITS'(span_lo) : SUM_BITS'(span_hi);
  assign carry_in = add_span ? SUM_BITS'(2) : '0;
  assign sum      = acc + opnd_p + ~opnd_q + carry_in;

endmodule

`default_nettype wire

[sv/interval_union_membership_table_core.sv]
// Interval union membership table: top level with the entry memory and sequencer.
// Depends on iumt_pkg and iumt_span_unit.
`default_nettype none

// The block holds up to MAX_ENTRIES disjoint inclusive ID ranges, sorted by start,
// in a single-port memory with registered read data. One item is worked at a time
// and in_stall stays high until its result has been loaded into the output
// register; the next item may be taken while that result still waits for its
// transfer. All work goes through one compare and add unit, and each memory read
// is followed by a state that uses or writes back its data. A clear or an unused
// operation goes from dispatch straight to the done state. A query is a binary
// search over the stored ranges. An add scans the stored ranges in order up to the
// first range past the new one, then moves the tail of the table one memory slot
// at a time (up for an insert, down when several ranges merge), and finally
// writes the new range. A range whose end lies below its start is dropped with
// status 2, and a new range that needs a slot in a full table is dropped with
// status 1.
module interval_union_membership_table_core #(
  parameter  int MAX_ENTRIES = 256,
  parameter  int ID_BITS     = 48,
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [iumt_pkg::OP_BITS-1:0]        in_operation,
  input  logic [ID_BITS-1:0]                  in_range_start,
  input  logic [ID_BITS-1:0]                  in_range_end,
  input  logic [ID_BITS-1:0]                  in_query_id,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_member,
  output logic [ID_BITS:0]                    out_covered_total,
  output logic [iumt_pkg::HIT_BITS-1:0]       out_hit_total,
  output logic [CNT_BITS-1:0]                 out_entry_total,
  output logic [iumt_pkg::STATUS_BITS-1:0]    out_status
);
  import iumt_pkg::*;

  localparam int ADDR_BITS = $clog2(MAX_ENTRIES);
  localparam int WORD_BITS = 2 * ID_BITS;

  // Entry memory: {start, end} per slot.
  logic [WORD_BITS-1:0] entry_mem [MAX_ENTRIES];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Sequencer and working registers.
  state_t               state_r;
  state_t               state_nxt;
  logic [OP_BITS-1:0]   op_r;
  logic [ID_BITS-1:0]   s_r;
  logic [ID_BITS-1:0]   e_r;
  logic [ID_BITS-1:0]   ns_r;
  logic [ID_BITS-1:0]   ne_r;
  logic [ID_BITS:0]     acc_r;
  logic [CNT_BITS-1:0]  idx_r;
  logic [CNT_BITS-1:0]  first_r;
  logic [CNT_BITS-1:0]  k_r;
  logic [CNT_BITS-1:0]  lo_r;
  logic [CNT_BITS-1:0]  hi_r;
  logic [CNT_BITS-1:0]  mid_r;
  logic                 member_r;
  logic [STATUS_BITS-1:0] status_r;

  // Committed table state.
  logic [CNT_BITS-1:0]  count_r;
  logic [ID_BITS:0]     covered_r;
  logic [HIT_BITS-1:0]  hits_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_member_r;
  logic [ID_BITS:0]       out_covered_r;
  logic [HIT_BITS-1:0]    out_hits_r;
  logic [CNT_BITS-1:0]    out_entries_r;
  logic [STATUS_BITS-1:0] out_status_r;

  // Derived values.
  logic                 in_take;
  logic                 done_load;
  logic                 order_bad;
  logic [ID_BITS-1:0]   rd_start;
  logic [ID_BITS-1:0]   rd_end;
  logic [CNT_BITS-1:0]  idx_inc;
  logic [CNT_BITS-1:0]  mid_inc;
  logic [CNT_BITS-1:0]  past;
  logic [CNT_BITS-1:0]  dn_addr;
  logic [CNT_BITS:0]    mid_sum;
  logic [CNT_BITS-1:0]  mid;
  logic                 table_full;
  logic                 add_span;
  logic [ID_BITS-1:0]   span_lo;
  logic [ID_BITS-1:0]   span_hi;
  cmp_flags_t           flags;
  logic [ID_BITS:0]     unit_sum;

  assign in_take   = in_valid && !in_stall;
  assign done_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign order_bad = (e_r < s_r);
  assign rd_start  = rd_data_r[WORD_BITS-1:ID_BITS];
  assign rd_end    = rd_data_r[ID_BITS-1:0];
  assign idx_inc   = idx_r + CNT_BITS'(1);
  assign mid_inc   = mid_r + CNT_BITS'(1);
  assign past      = first_r + k_r;
  assign dn_addr   = idx_r - k_r + CNT_BITS'(1);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[CNT_BITS:1];
  assign table_full = (count_r == CNT_BITS'(MAX_ENTRIES));

  // Shared compare and span unit.
  assign add_span = (state_r == S_WRITE);
  assign span_lo  = add_span ? ns_r : rd_start;
  assign span_hi  = add_span ? ne_r : rd_end;

  iumt_span_unit #(
    .ID_BITS (ID_BITS)
  ) u_span_unit (
    .entry_start (rd_start),
    .entry_end   (rd_end),
    .key_lo      (s_r),
    .key_hi      (e_r),
    .add_span    (add_span),
    .span_lo     (span_lo),
    .span_hi     (span_hi),
    .acc         (acc_r),
    .flags       (flags),
    .sum         (unit_sum)
  );

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= entry_mem[mem_raddr];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_r)
          OP_ADD: begin
            if (order_bad) begin
              state_nxt = S_DONE;
            end else if (count_r == '0) begin
              state_nxt = S_PLACE;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          OP_QUERY: begin
            state_nxt = (count_r == '0) ? S_DONE : S_QRY_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (!flags.end_below_lo && flags.hi_below_start) begin
          state_nxt = S_PLACE;
        end else if (idx_inc == count_r) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_PLACE: begin
        if (k_r == '0) begin
          if (table_full) begin
            state_nxt = S_DONE;
          end else if (first_r == count_r) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_UP_RD;
          end
        end else if (k_r == CNT_BITS'(1) || past == count_r) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_UP_RD: state_nxt = S_UP_WR;
      S_UP_WR: state_nxt = (idx_r == first_r) ? S_WRITE : S_UP_RD;
      S_DN_RD: state_nxt = S_DN_WR;
      S_DN_WR: state_nxt = (idx_inc == count_r) ? S_WRITE : S_DN_RD;
      S_WRITE: state_nxt = S_DONE;
      S_QRY_RD: state_nxt = S_QRY_EV;
      S_QRY_EV: begin
        if (flags.hi_below_start) begin
          state_nxt = (lo_r < mid_r) ? S_QRY_RD : S_DONE;
        end else if (flags.end_below_lo) begin
          state_nxt = (mid_inc < hi_r) ? S_QRY_RD : S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port controls per state.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_r[ADDR_BITS-1:0];
    mem_we    = 1'b0;
    mem_waddr = first_r[ADDR_BITS-1:0];
    mem_wdata = rd_data_r;
    unique case (state_r)
      S_SCAN_RD, S_UP_RD, S_DN_RD: begin
        mem_re = 1'b1;
      end
      S_QRY_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mid[ADDR_BITS-1:0];
      end
      S_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc[ADDR_BITS-1:0];
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dn_addr[ADDR_BITS-1:0];
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {ns_r, ne_r};
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Committed counters: entry count, covered IDs and query hits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      covered_r <= '0;
      hits_r    <= '0;
    end else begin
      case (state_r)
        S_DISPATCH: begin
          if (op_r == OP_CLEAR) begin
            count_r   <= '0;
            covered_r <= '0;
            hits_r    <= '0;
          end
        end
        S_QRY_EV: begin
          if (!flags.hi_below_start && !flags.end_below_lo &&
              hits_r != {HIT_BITS{1'b1}}) begin
            hits_r <= hits_r + HIT_BITS'(1);
          end
        end
        S_WRITE: begin
          covered_r <= unit_sum;
          if (k_r == '0) begin
            count_r <= count_r + CNT_BITS'(1);
          end else begin
            count_r <= count_r - k_r + CNT_BITS'(1);
          end
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  // Working registers of the scan, the tail moves and the search.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_r <= in_operation;
          if (in_operation == OP_QUERY) begin
            s_r <= in_query_id;
            e_r <= in_query_id;
          end else begin
            s_r <= in_range_start;
            e_r <= in_range_end;
          end
        end
      end
      S_DISPATCH: begin
        member_r <= 1'b0;
        status_r <= (op_r == OP_ADD && order_bad) ? ST_ORDER : ST_OK;
        acc_r    <= covered_r;
        ns_r     <= s_r;
        ne_r     <= e_r;
        idx_r    <= '0;
        first_r  <= '0;
        k_r      <= '0;
        lo_r     <= '0;
        hi_r     <= count_r;
      end
      S_SCAN_EV: begin
        idx_r <= idx_inc;
        if (flags.end_below_lo) begin
          first_r <= first_r + CNT_BITS'(1);
        end else if (!flags.hi_below_start) begin
          // Overlapping range: remove its span and widen the merged range.
          k_r   <= k_r + CNT_BITS'(1);
          acc_r <= unit_sum;
          if (k_r == '0) begin
            ns_r <= flags.start_below_lo ? rd_start : s_r;
          end
          ne_r <= flags.hi_below_end ? rd_end : e_r;
        end
      end
      S_PLACE: begin
        if (k_r == '0) begin
          if (table_full) begin
            status_r <= ST_FULL;
          end
          idx_r <= count_r - CNT_BITS'(1);
        end else begin
          idx_r <= past;
        end
      end
      S_UP_WR: begin
        idx_r <= idx_r - CNT_BITS'(1);
      end
      S_DN_WR: begin
        idx_r <= idx_inc;
      end
      S_QRY_RD: begin
        mid_r <= mid;
      end
      S_QRY_EV: begin
        if (flags.hi_below_start) begin
          hi_r <= mid_r;
        end else if (flags.end_below_lo) begin
          lo_r <= mid_inc;
        end else begin
          member_r <= 1'b1;
        end
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

  // Output register: the result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_member_r  <= member_r;
      out_covered_r <= covered_r;
      out_hits_r    <= hits_r;
      out_entries_r <= count_r;
      out_status_r  <= status_r;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_is_member     = out_member_r;
  assign out_covered_total = out_covered_r;
  assign out_hit_total     = out_hits_r;
  assign out_entry_total   = out_entries_r;
  assign out_status        = out_status_r;

endmodule

`default_nettype wire

[sv/iumt_checker.sv]
// Port-level checker for the interval union membership table, bound to its top level.
// Depends on iumt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module iumt_checker #(
  parameter  int MAX_ENTRIES = 256,
  parameter  int ID_BITS     = 48,
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_is_member,
  input  logic [ID_BITS:0]                 out_covered_total,
  input  logic [iumt_pkg::HIT_BITS-1:0]    out_hit_total,
  input  logic [CNT_BITS-1:0]              out_entry_total,
  input  logic [iumt_pkg::STATUS_BITS-1:0] out_status
);
  import iumt_pkg::*;

  // A result held back by the receiver keeps its counters.
  `IUMT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_covered_total) && $stable(out_entry_total) && $stable(out_hit_total), "stalled result changed")

  // Once an item is taken the block is busy in the following cycle.
  `IUMT_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "block not busy after input transfer")

  // A hit only comes from a query of a nonempty table and is counted.
  `IUMT_ASSERT_IMP(a_hit_sane, clk, rst_n, out_valid && out_is_member, out_status == ST_OK && out_entry_total != '0 && out_hit_total != '0, "hit result inconsistent")

  // An empty table covers no IDs.
  `IUMT_ASSERT_IMP(a_empty_cover, clk, rst_n, out_valid && out_entry_total == '0, out_covered_total == '0, "empty table reports coverage")

  // The entry count never exceeds the table size.
  `IUMT_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_entry_total <= CNT_BITS'(MAX_ENTRIES), "entry count above table size")

endmodule

bind interval_union_membership_table_core iumt_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .ID_BITS     (ID_BITS)
) u_iumt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_is_member     (out_is_member),
  .out_covered_total (out_covered_total),
  .out_hit_total     (out_hit_total),
  .out_entry_total   (out_entry_total),
  .out_status        (out_status)
);

`default_nettype wire
